/* rtl/gsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsc_pkg
// Shared constants and types of the glyph slot cache.
// ----------------------------------------------------------------------------
package gsc_pkg;

    localparam int SLOTS_DEF      = 64;
    localparam int CHAR_CODES_DEF = 65536;
    localparam int AGE_BITS_DEF   = 16;

    // fixed port widths
    localparam int CODE_W      = 16;
    localparam int SLOT_PORT_W = 6;

    localparam logic REQ_DRAW = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_LOOKUP,
        ST_CHECK,
        ST_SCAN,
        ST_EVICT,
        ST_TICK
    } t_state;

endpackage

/* rtl/gsc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/glyph_slot_cache_aging_replacement.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_slot_cache_aging_replacement
// Direct-mapped character to slot cache with age-counter replacement.
//
// Request channel: i_start with i_req_type / i_char_code, taken when o_busy
// is low. A draw request looks up the slot mapped to the character; a frame
// tick ages every slot by one, saturating.
// Result channel: o_valid strobes one cycle per request with o_slot, o_hit,
// o_load_needed, o_evicted and o_evicted_char. The receiver cannot stall,
// so results are never held back. The next request can be taken in the
// cycle the result is shown.
// Steps per request, paced by the registered map, owner and age reads:
//   draw hit or miss with a free slot: code reduction, map lookup, check
//   draw miss with all slots full: those plus the age scan and the eviction
//   frame tick: read-modify-write sweep of the age memory
// Reset empties the cache at once: slots fill in order from slot 1, so a
// fill count stands for the valid bits, and a hit also needs a matching
// owner tag, so the map memory needs no clearing pass.
// ----------------------------------------------------------------------------
module glyph_slot_cache_aging_replacement #(
    parameter int SLOTS      = gsc_pkg::SLOTS_DEF,
    parameter int CHAR_CODES = gsc_pkg::CHAR_CODES_DEF,
    parameter int AGE_BITS   = gsc_pkg::AGE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic                             i_req_type,
    input  logic [gsc_pkg::CODE_W-1:0]       i_char_code,
    output logic                             o_valid,
    output logic [gsc_pkg::SLOT_PORT_W-1:0]  o_slot,
    output logic                             o_hit,
    output logic                             o_load_needed,
    output logic                             o_evicted,
    output logic [gsc_pkg::CODE_W-1:0]       o_evicted_char
);

    import gsc_pkg::*;

    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CHAR_W    = $clog2(CHAR_CODES);
    localparam int IDX_W     = $clog2(SLOTS + 1);
    localparam int RED_STEPS = CODE_W + 1 - CHAR_W;
    localparam int RK_W      = $clog2(RED_STEPS) + 1;

    t_state r_state, n_state;

    logic [CODE_W-1:0]   r_code, n_code;
    logic [RK_W-1:0]     r_k, n_k;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [SLOT_W-1:0]   r_fill, n_fill;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [AGE_BITS-1:0] r_best, n_best;

    logic                   r_valid, n_valid;
    logic [SLOT_PORT_W-1:0] r_oslot, n_oslot;
    logic                   r_hit, n_hit;
    logic                   r_load, n_load;
    logic                   r_evicted, n_evicted;
    logic [CODE_W-1:0]      r_evchar, n_evchar;

    // memory ports
    logic                  map_we;
    logic [CHAR_W-1:0]     map_waddr, map_raddr;
    logic [SLOT_W-1:0]     map_wdata, map_rdata;
    logic                  own_we;
    logic [SLOT_W-1:0]     own_waddr, own_raddr;
    logic [CHAR_W-1:0]     own_wdata, own_rdata;
    logic                  age_we;
    logic [SLOT_W-1:0]     age_waddr, age_raddr;
    logic [AGE_BITS-1:0]   age_wdata, age_rdata;

    logic [31:0]           red_lim;
    logic [CODE_W-1:0]     red_code;
    logic [SLOT_W-1:0]     pidx;
    logic [SLOT_W-1:0]     victim;
    logic                  is_hit;
    logic [SLOT_W+SLOT_PORT_W-1:0] slot_ext;
    logic [CHAR_W+CODE_W-1:0]      own_ext;

    gsc_ram #(.WIDTH(SLOT_W), .DEPTH(CHAR_CODES)) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    gsc_ram #(.WIDTH(CHAR_W), .DEPTH(SLOTS)) u_owner (
        .i_clk   (i_clk),
        .i_we    (own_we),
        .i_waddr (own_waddr),
        .i_wdata (own_wdata),
        .i_raddr (own_raddr),
        .o_rdata (own_rdata)
    );

    gsc_ram #(.WIDTH(AGE_BITS), .DEPTH(SLOTS)) u_age (
        .i_clk   (i_clk),
        .i_we    (age_we),
        .i_waddr (age_waddr),
        .i_wdata (age_wdata),
        .i_raddr (age_raddr),
        .o_rdata (age_rdata)
    );

    // one restoring step of the code reduction modulo CHAR_CODES
    assign red_lim  = 32'(CHAR_CODES) << r_k;
    assign red_code = ({16'b0, r_code} >= red_lim) ? (r_code - red_lim[CODE_W-1:0]) : r_code;

    assign pidx   = SLOT_W'(r_idx - 1'b1);
    assign victim = r_fill + 1'b1;
    assign is_hit = (r_slot != '0) && (r_slot <= r_fill) && (own_rdata == r_code[CHAR_W-1:0]);

    always_comb begin
        n_state   = r_state;
        n_code    = r_code;
        n_k       = r_k;
        n_slot    = r_slot;
        n_fill    = r_fill;
        n_idx     = r_idx;
        n_best    = r_best;
        n_valid   = 1'b0;
        n_oslot   = r_oslot;
        n_hit     = r_hit;
        n_load    = r_load;
        n_evicted = r_evicted;
        n_evchar  = r_evchar;

        map_we    = 1'b0;
        map_waddr = r_code[CHAR_W-1:0];
        map_wdata = r_slot;
        map_raddr = red_code[CHAR_W-1:0];
        own_we    = 1'b0;
        own_waddr = r_slot;
        own_wdata = r_code[CHAR_W-1:0];
        own_raddr = map_rdata;
        age_we    = 1'b0;
        age_waddr = r_slot;
        age_wdata = AGE_BITS'(1);
        age_raddr = r_idx[SLOT_W-1:0];

        slot_ext  = '0;
        own_ext   = '0;

        case (r_state)
            ST_IDLE: begin
                age_raddr = '0;
                if (i_start) begin
                    if (i_req_type == REQ_TICK) begin
                        n_idx   = IDX_W'(1);
                        n_state = ST_TICK;
                    end else begin
                        n_code  = i_char_code;
                        n_k     = RK_W'(RED_STEPS - 1);
                        n_state = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                n_code = red_code;
                if (r_k == '0) begin
                    n_state = ST_LOOKUP;
                end else begin
                    n_k = r_k - 1'b1;
                end
            end
            ST_LOOKUP: begin
                n_slot  = map_rdata;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                age_raddr = SLOT_W'(1);
                if (is_hit) begin
                    age_we  = 1'b1;
                    slot_ext = {{SLOT_PORT_W{1'b0}}, r_slot};
                    n_valid = 1'b1;
                    n_oslot = slot_ext[SLOT_PORT_W-1:0];
                    n_hit   = 1'b1;
                    n_load  = 1'b0;
                    n_evicted = 1'b0;
                    n_evchar  = '0;
                    n_state = ST_IDLE;
                end else if (r_fill < SLOT_W'(SLOTS - 1)) begin
                    // a free slot remains: the next one after the filled prefix
                    map_we    = 1'b1;
                    map_wdata = victim;
                    own_we    = 1'b1;
                    own_waddr = victim;
                    age_we    = 1'b1;
                    age_waddr = victim;
                    n_fill    = victim;
                    slot_ext  = {{SLOT_PORT_W{1'b0}}, victim};
                    n_valid   = 1'b1;
                    n_oslot   = slot_ext[SLOT_PORT_W-1:0];
                    n_hit     = 1'b0;
                    n_load    = 1'b1;
                    n_evicted = 1'b0;
                    n_evchar  = '0;
                    n_state   = ST_IDLE;
                end else begin
                    n_idx   = IDX_W'(2);
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // age of slot pidx is on the read port; first greatest wins
                if (pidx == SLOT_W'(1) || age_rdata > r_best) begin
                    n_best = age_rdata;
                    n_slot = pidx;
                end
                own_raddr = n_slot;
                if (r_idx == IDX_W'(SLOTS)) begin
                    n_state = ST_EVICT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_EVICT: begin
                map_we    = 1'b1;
                own_we    = 1'b1;
                age_we    = 1'b1;
                slot_ext  = {{SLOT_PORT_W{1'b0}}, r_slot};
                own_ext   = {{CODE_W{1'b0}}, own_rdata};
                n_valid   = 1'b1;
                n_oslot   = slot_ext[SLOT_PORT_W-1:0];
                n_hit     = 1'b0;
                n_load    = 1'b1;
                n_evicted = 1'b1;
                n_evchar  = own_ext[CODE_W-1:0];
                n_state   = ST_IDLE;
            end
            ST_TICK: begin
                // write back slot pidx while reading the next one
                age_we    = 1'b1;
                age_waddr = pidx;
                age_wdata = (age_rdata == '1) ? age_rdata : age_rdata + 1'b1;
                if (r_idx == IDX_W'(SLOTS)) begin
                    n_valid   = 1'b1;
                    n_oslot   = '0;
                    n_hit     = 1'b0;
                    n_load    = 1'b0;
                    n_evicted = 1'b0;
                    n_evchar  = '0;
                    n_state   = ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code    <= n_code;
        r_k       <= n_k;
        r_slot    <= n_slot;
        r_idx     <= n_idx;
        r_best    <= n_best;
        r_oslot   <= n_oslot;
        r_hit     <= n_hit;
        r_load    <= n_load;
        r_evicted <= n_evicted;
        r_evchar  <= n_evchar;
    end

    assign o_busy         = (r_state != ST_IDLE);
    assign o_valid        = r_valid;
    assign o_slot         = r_oslot;
    assign o_hit          = r_hit;
    assign o_load_needed  = r_load;
    assign o_evicted      = r_evicted;
    assign o_evicted_char = r_evchar;

endmodule
